// File: rtl/rrva_pkg.sv
`default_nettype none

package rrva_pkg;

    localparam logic [6:0] NOTE_MAX = 7'h7F;
    localparam logic [3:0] VOICE_BASE_RESET = 4'd6;

    localparam logic CMD_NOTE_ON  = 1'b0;
    localparam logic CMD_NOTE_OFF = 1'b1;

    localparam logic ACT_NOTE_OFF = 1'b0;
    localparam logic ACT_NOTE_ON  = 1'b1;

    // control broadcast to every cell
    typedef struct packed {
        logic take;       // note-on: cursor cell takes the note
        logic start_off;  // note-off: latch matches, token to head cell
        logic step;       // move scan token one cell on
        logic release_hit; // token cell has been reported, free it
    } rrva_cell_ctl_t;

    // per-cell status, OR-reduced by the top level
    typedef struct packed {
        logic hit;    // token here and cell holds a pending match
        logic tail;   // token here and no pending match further on
        logic steal;  // cursor here and cell busy
    } rrva_cell_sts_t;

endpackage

`default_nettype wire

// File: rtl/rrva_cell.sv
`default_nettype none

module rrva_cell
    import rrva_pkg::*;
#(
    parameter bit IS_HEAD = 1'b0
)
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire rrva_cell_ctl_t ctl,
    input  wire logic [6:0]     key,
    input  wire logic           tok_in,
    input  wire logic           cur_in,
    input  wire logic           rest_in,
    output logic                tok_out,
    output logic                cur_out,
    output logic                rest_out,
    output rrva_cell_sts_t      sts
);

    logic       busy_reg, busy_next;
    logic [6:0] note_reg, note_next;
    logic       pend_reg, pend_next;
    logic       tok_reg,  tok_next;
    logic       cur_reg,  cur_next;

    always_comb
    begin
        busy_next = busy_reg;
        note_next = note_reg;
        pend_next = pend_reg;
        tok_next  = tok_reg;
        cur_next  = cur_reg;
        if (ctl.take)
        begin
            cur_next = cur_in;
            if (cur_reg)
            begin
                busy_next = 1'b1;
                note_next = key;
            end
        end
        if (ctl.start_off)
        begin
            pend_next = busy_reg && (note_reg == key);
            tok_next  = IS_HEAD;
        end
        else if (ctl.step)
        begin
            tok_next = tok_in;
        end
        if (ctl.release_hit && tok_reg && pend_reg)
        begin
            pend_next = 1'b0;
            busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            pend_reg <= 1'b0;
            tok_reg  <= 1'b0;
            cur_reg  <= IS_HEAD;
        end
        else
        begin
            busy_reg <= busy_next;
            pend_reg <= pend_next;
            tok_reg  <= tok_next;
            cur_reg  <= cur_next;
        end
    end

    always_ff @(posedge clk)
    begin
        note_reg <= note_next;
    end

    assign tok_out   = tok_reg;
    assign cur_out   = cur_reg;
    assign rest_out  = pend_reg | rest_in;
    assign sts.hit   = tok_reg & pend_reg;
    assign sts.tail  = tok_reg & ~rest_in;
    assign sts.steal = cur_reg & busy_reg;

endmodule

`default_nettype wire

// File: rtl/round_robin_voice_allocator_top.sv
// Round-robin voice allocator.
// Input channel (in_valid/in_stall): cmd, note, velocity. A request is taken
// when in_valid is high and in_stall low. Output channel (out_valid/out_stall):
// action, voice, note_out, vel_out, last; last marks a request's final result.
// Config channel (cfg_valid/cfg_ready/cfg_data) writes voice_base; always ready.
// Note-on: one or two results, one a cycle while the output is not stalled;
// the next request is taken once the last result is registered.
// Note-off: a token walks the slot cells one per cycle, waiting at a matching
// slot while the output is stalled, and emits one note-off per matching slot.
// Requests with a note above 127 are taken and produce nothing.
// A stall on a valid output holds the output register and any result waiting to load.
// Reset: all slots empty, cursor at slot 0, voice_base 6.
`default_nettype none

module round_robin_voice_allocator_top
    import rrva_pkg::*;
#(
    parameter int SLOTS = 6
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic       cmd,
    input  wire logic [7:0] note,
    input  wire logic [7:0] velocity,
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic            action,
    output logic [4:0]      voice,
    output logic [6:0]      note_out,
    output logic [6:0]      vel_out,
    output logic            last,
    input  wire logic       cfg_valid,
    output logic            cfg_ready,
    input  wire logic [3:0] cfg_data
);

    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_STEAL = 2'd2;
    localparam logic [1:0] ST_ON    = 2'd3;

    logic [1:0]        state_reg, state_next;
    logic [3:0]        voice_base_reg;
    logic [SLOT_W-1:0] slot_reg;
    logic [6:0]        on_note_reg;
    logic [6:0]        on_vel_reg;

    logic              out_valid_reg, out_valid_next;
    logic              action_reg, action_next;
    logic [4:0]        voice_reg, voice_next;
    logic [6:0]        note_out_reg, note_out_next;
    logic [6:0]        vel_out_reg, vel_out_next;
    logic              last_reg, last_next;

    rrva_cell_ctl_t    ctl;
    rrva_cell_sts_t    sts [SLOTS];
    logic [SLOTS-1:0]  tok_w;
    logic [SLOTS-1:0]  cur_w;
    logic [SLOTS:0]    rest_w;

    logic              accept;
    logic              can_load;
    logic              hit_any, tail_any, steal_any;
    logic [SLOT_W-1:0] cur_idx, tok_idx;

    assign rest_w[SLOTS] = 1'b0;

    for (genvar g = 0; g < SLOTS; g++)
    begin : g_cell
        rrva_cell #(
            .IS_HEAD (g == 0)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctl      (ctl),
            .key      (note[6:0]),
            .tok_in   ((g == 0) ? 1'b0 : tok_w[(g + SLOTS - 1) % SLOTS]),
            .cur_in   (cur_w[(g + SLOTS - 1) % SLOTS]),
            .rest_in  (rest_w[g + 1]),
            .tok_out  (tok_w[g]),
            .cur_out  (cur_w[g]),
            .rest_out (rest_w[g]),
            .sts      (sts[g])
        );
    end

    always_comb
    begin
        hit_any   = 1'b0;
        tail_any  = 1'b0;
        steal_any = 1'b0;
        cur_idx   = '0;
        tok_idx   = '0;
        for (int i = 0; i < SLOTS; i++)
        begin
            hit_any   = hit_any | sts[i].hit;
            tail_any  = tail_any | sts[i].tail;
            steal_any = steal_any | sts[i].steal;
            cur_idx   = cur_idx | (cur_w[i] ? SLOT_W'(i) : '0);
            tok_idx   = tok_idx | (tok_w[i] ? SLOT_W'(i) : '0);
        end
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign accept    = in_valid && !in_stall;
    assign can_load  = !out_valid_reg || !out_stall;
    assign cfg_ready = 1'b1;

    always_comb
    begin
        state_next      = state_reg;
        ctl             = '0;
        out_valid_next  = out_valid_reg && out_stall;
        action_next     = action_reg;
        voice_next      = voice_reg;
        note_out_next   = note_out_reg;
        vel_out_next    = vel_out_reg;
        last_next       = last_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && !note[7])
                begin
                    if (cmd == CMD_NOTE_ON)
                    begin
                        ctl.take   = 1'b1;
                        state_next = steal_any ? ST_STEAL : ST_ON;
                    end
                    else
                    begin
                        ctl.start_off = 1'b1;
                        state_next    = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                if (!hit_any || can_load)
                begin
                    ctl.step = 1'b1;
                    if (hit_any)
                    begin
                        ctl.release_hit = 1'b1;
                        out_valid_next  = 1'b1;
                        action_next     = ACT_NOTE_OFF;
                        voice_next      = 5'(voice_base_reg) + 5'(tok_idx);
                        note_out_next   = '0;
                        vel_out_next    = '0;
                        last_next       = tail_any;
                    end
                    if (tail_any)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_STEAL:
            begin
                if (can_load)
                begin
                    out_valid_next = 1'b1;
                    action_next    = ACT_NOTE_OFF;
                    voice_next     = 5'(voice_base_reg) + 5'(slot_reg);
                    note_out_next  = '0;
                    vel_out_next   = '0;
                    last_next      = 1'b0;
                    state_next     = ST_ON;
                end
            end
            ST_ON:
            begin
                if (can_load)
                begin
                    out_valid_next = 1'b1;
                    action_next    = ACT_NOTE_ON;
                    voice_next     = 5'(voice_base_reg) + 5'(slot_reg);
                    note_out_next  = on_note_reg;
                    vel_out_next   = on_vel_reg;
                    last_next      = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            out_valid_reg  <= 1'b0;
            voice_base_reg <= VOICE_BASE_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                voice_base_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            slot_reg    <= cur_idx;
            on_note_reg <= note[6:0];
            on_vel_reg  <= velocity[7] ? NOTE_MAX : velocity[6:0];
        end
        action_reg   <= action_next;
        voice_reg    <= voice_next;
        note_out_reg <= note_out_next;
        vel_out_reg  <= vel_out_next;
        last_reg     <= last_next;
    end

    assign out_valid = out_valid_reg;
    assign action    = action_reg;
    assign voice     = voice_reg;
    assign note_out  = note_out_reg;
    assign vel_out   = vel_out_reg;
    assign last      = last_reg;

endmodule

`default_nettype wire

// File: sim/round_robin_voice_allocator_top_tb.sv
`timescale 1ns / 100ps

module round_robin_voice_allocator_top_tb;
    import rrva_pkg::*;

    localparam int SLOTS = 6;
    localparam int DRAIN_CYCLES = 2 * SLOTS + 8;
    localparam int CYCLE_LIMIT = 300000;
    localparam int LONG_HOLD = 120;
    localparam int PHASE_REQUESTS = 44;
    localparam int RANDOM_PHASES = 4;

    typedef struct packed {
        logic       action;
        logic [4:0] voice;
        logic [6:0] note;
        logic [6:0] vel;
        logic       last;
    } voice_event_t;

    // slot occupancy and the voice events each request should cause
    class voice_alloc_model;
        logic [7:0]   held_note[SLOTS];
        bit           busy[SLOTS];
        int unsigned  cursor;
        logic [3:0]   base;
        voice_event_t events_due[$];
        int           errors;

        function new();
            for (int i = 0; i < SLOTS; i++)
            begin
                held_note[i] = '0;
                busy[i] = 1'b0;
            end
            cursor = 0;
            base = VOICE_BASE_RESET;
            errors = 0;
        endfunction

        function logic [4:0] voice_of(int unsigned slot);
            return 5'(base) + 5'(slot);
        endfunction

        function void push_event(logic act, int unsigned slot, logic [6:0] n,
                                 logic [6:0] v, logic fin);
            voice_event_t ev;
            ev.action = act;
            ev.voice = voice_of(slot);
            ev.note = n;
            ev.vel = v;
            ev.last = fin;
            events_due.push_back(ev);
        endfunction

        function void take_request(logic c, logic [7:0] n, logic [7:0] v);
            int unsigned slot;
            int hits;
            int k;
            logic [6:0] sat_vel;
            if (n > 8'(NOTE_MAX))
                return;
            if (c == CMD_NOTE_ON)
            begin
                slot = cursor;
                sat_vel = (v > 8'(NOTE_MAX)) ? NOTE_MAX : v[6:0];
                cursor = (slot + 1) % SLOTS;
                if (busy[slot])
                    push_event(ACT_NOTE_OFF, slot, '0, '0, 1'b0);
                held_note[slot] = n;
                busy[slot] = 1'b1;
                push_event(ACT_NOTE_ON, slot, n[6:0], sat_vel, 1'b1);
            end
            else
            begin
                hits = 0;
                for (int i = 0; i < SLOTS; i++)
                    if (busy[i] && held_note[i] == n)
                        hits++;
                k = 0;
                for (int i = 0; i < SLOTS; i++)
                begin
                    if (busy[i] && held_note[i] == n)
                    begin
                        k++;
                        push_event(ACT_NOTE_OFF, i, '0, '0, k == hits);
                        busy[i] = 1'b0;
                        held_note[i] = '0;
                    end
                end
            end
        endfunction

        function void compare(string field, int unsigned want, int unsigned got);
            if (want != got)
            begin
                $error("%s mismatch: expected %0d, actual %0d", field, want, got);
                errors++;
            end
        endfunction

        function void check_voice_event(voice_event_t got);
            voice_event_t want;
            if (events_due.size() == 0)
            begin
                $error("unexpected result: action %0d voice %0d note %0d vel %0d last %0d",
                       got.action, got.voice, got.note, got.vel, got.last);
                errors++;
                return;
            end
            want = events_due.pop_front();
            compare("action", want.action, got.action);
            compare("voice", want.voice, got.voice);
            compare("note_out", want.note, got.note);
            compare("vel_out", want.vel, got.vel);
            compare("last", want.last, got.last);
        endfunction
    endclass

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    logic       cmd;
    logic [7:0] note;
    logic [7:0] velocity;
    logic       out_valid;
    logic       out_stall;
    logic       action;
    logic [4:0] voice;
    logic [6:0] note_out;
    logic [6:0] vel_out;
    logic       last;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [3:0] cfg_data;

    voice_alloc_model alloc;
    bit hold_armed;
    int cycle_count;
    logic [7:0] note_pool[8];

    round_robin_voice_allocator_top #(
        .SLOTS(SLOTS)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .cmd(cmd),
        .note(note),
        .velocity(velocity),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .action(action),
        .voice(voice),
        .note_out(note_out),
        .vel_out(vel_out),
        .last(last),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                alloc.take_request(cmd, note, velocity);
            if (out_valid && !out_stall)
                alloc.check_voice_event({action, voice, note_out, vel_out, last});
        end
    end

    // receiver: stall pattern in segments, with an occasional long hold
    initial
    begin
        int mode;
        int seg_len;
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_armed)
            begin
                hold_armed = 1'b0;
                @(negedge clk);
                out_stall = 1'b1;
                repeat (LONG_HOLD - 1) @(negedge clk);
            end
            mode = $urandom_range(0, 2);
            seg_len = $urandom_range(10, 60);
            repeat (seg_len)
            begin
                @(negedge clk);
                case (mode)
                    0: out_stall = 1'b0;
                    1: out_stall = ($urandom_range(0, 99) < 30);
                    default: out_stall = ($urandom_range(0, 99) < 75);
                endcase
            end
        end
    end

    // called at a falling edge, returns at a falling edge
    task automatic send_request(logic c, logic [7:0] n, logic [7:0] v);
        in_valid = 1'b1;
        cmd = c;
        note = n;
        velocity = v;
        do
            @(posedge clk);
        while (in_stall);
        @(negedge clk);
    endtask

    task automatic idle_sender(int cycles);
        in_valid = 1'b0;
        repeat (cycles) @(negedge clk);
    endtask

    // no-result requests may still be in flight once the queue empties
    task automatic settle_block();
        in_valid = 1'b0;
        while (alloc.events_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_voice_base(logic [3:0] value);
        cfg_valid = 1'b1;
        cfg_data = value;
        do
            @(posedge clk);
        while (!cfg_ready);
        alloc.base = value;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic random_request(output logic c, output logic [7:0] n,
                                  output logic [7:0] v);
        int pick;
        pick = $urandom_range(0, 99);
        v = 8'($urandom_range(0, 255));
        if (pick < 6)
        begin
            c = 1'($urandom_range(0, 1));
            n = 8'($urandom_range(128, 255));
        end
        else
        begin
            c = ($urandom_range(0, 99) < 55) ? CMD_NOTE_ON : CMD_NOTE_OFF;
            if ($urandom_range(0, 3) == 0)
                n = 8'($urandom_range(0, 127));
            else
                n = note_pool[3'($urandom_range(0, 7))];
        end
    endtask

    initial
    begin
        logic       c;
        logic [7:0] n;
        logic [7:0] v;
        int burst_left;
        int sent;
        alloc = new();
        cycle_count = 0;
        hold_armed = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        cmd = 1'b0;
        note = '0;
        velocity = '0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // reset base, saturation, ignored notes, wrap and stealing
        send_request(CMD_NOTE_ON, 8'd60, 8'd0);
        send_request(CMD_NOTE_ON, 8'd127, 8'd255);
        send_request(CMD_NOTE_ON, 8'd0, 8'd127);
        send_request(CMD_NOTE_ON, 8'd200, 8'd255);
        send_request(CMD_NOTE_OFF, 8'd200, 8'd0);
        send_request(CMD_NOTE_OFF, 8'd61, 8'd255);
        send_request(CMD_NOTE_OFF, 8'd60, 8'd0);
        send_request(CMD_NOTE_ON, 8'd5, 8'd128);
        send_request(CMD_NOTE_ON, 8'd5, 8'd100);
        send_request(CMD_NOTE_ON, 8'd5, 8'd64);
        send_request(CMD_NOTE_ON, 8'd9, 8'd1);
        send_request(CMD_NOTE_ON, 8'd10, 8'd85);
        send_request(CMD_NOTE_OFF, 8'd5, 8'd255);
        send_request(CMD_NOTE_ON, 8'd128, 8'd170);
        settle_block();

        // top base, every slot on one note, then a full release
        write_voice_base(4'd15);
        for (int i = 0; i < SLOTS; i++)
            send_request(CMD_NOTE_ON, 8'd127, (i % 2) ? 8'd85 : 8'd170);
        send_request(CMD_NOTE_OFF, 8'd127, 8'd0);
        settle_block();

        write_voice_base(4'd0);
        send_request(CMD_NOTE_ON, 8'd42, 8'd255);
        send_request(CMD_NOTE_OFF, 8'd42, 8'd127);
        send_request(CMD_NOTE_ON, 8'd255, 8'd0);
        settle_block();

        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            write_voice_base((p == RANDOM_PHASES - 1) ? 4'd15 : 4'($urandom_range(0, 15)));
            foreach (note_pool[i])
                note_pool[i] = 8'($urandom_range(0, 127));
            if (p == 0 || p == 2)
                hold_armed = 1'b1;
            burst_left = $urandom_range(1, 12);
            sent = 0;
            while (sent < PHASE_REQUESTS)
            begin
                if (burst_left == 0)
                begin
                    idle_sender($urandom_range(1, 6));
                    burst_left = $urandom_range(1, 12);
                end
                random_request(c, n, v);
                send_request(c, n, v);
                burst_left--;
                if (n <= 8'(NOTE_MAX))
                    sent++;
            end
            settle_block();
        end

        if (alloc.events_due.size() != 0)
        begin
            $error("%0d expected results never arrived", alloc.events_due.size());
            alloc.errors++;
        end
        if (alloc.errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
